// File: hw/rtl/fsog_pkg.sv
`default_nettype none

package fsog_pkg;

   // Window geometry and field widths.
   localparam int WINDOW_DEF  = 10;
   localparam int SPEED_W     = 16;
   localparam int CODE_W      = 2;
   localparam int PERCENT_W   = 7;
   localparam int CHECK_W     = 8;
   localparam int TIMER_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Register reset values.
   localparam logic [SPEED_W-1:0]   VARIANCE_LIMIT_RST = 16'd600;
   localparam logic [PERCENT_W-1:0] FIX_PERCENT_RST    = 7'd30;
   localparam logic [CHECK_W-1:0]   CHECK_TICKS_RST    = 8'd10;
   localparam logic [TIMER_W-1:0]   FIX_TICKS_RST      = 16'd20;
   localparam logic [TIMER_W-1:0]   RECOVERY_TICKS_RST = 16'd20;

   // Largest drive percent that is ever commanded.
   localparam logic [PERCENT_W-1:0] DRIVE_MAX = 7'd100;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_VARIANCE_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIX_PERCENT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_TICKS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIX_TICKS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_TICKS = 3'd4;

   // Result codes.
   typedef enum logic [CODE_W-1:0] {
      VERDICT_NONE    = 2'd0,
      VERDICT_OK      = 2'd1,
      VERDICT_REVVING = 2'd2
   } verdict_type;

   typedef enum logic [CODE_W-1:0] {
      CMD_NONE   = 2'd0,
      CMD_FIX    = 2'd1,
      CMD_RESUME = 2'd2
   } command_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic update;
      logic scan_rd;
      logic resolve;
      logic load_rsp;
   } fsog_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_needed;
      logic scan_last;
   } fsog_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/fsog_ram.sv
`default_nettype none

module fsog_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fsog_datapath.sv
`default_nettype none

module fsog_datapath
   import fsog_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fsog_cmd_type          cmd,
   output fsog_status_type            status,
   input  wire logic [SPEED_W-1:0]    req_fan_speed,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic      [CODE_W-1:0]     rsp_verdict,
   output logic      [CODE_W-1:0]     rsp_command,
   output logic      [PERCENT_W-1:0]  rsp_drive_percent
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);

   typedef enum logic [1:0] {
      PH_MONITOR  = 2'd0,
      PH_FIXING   = 2'd1,
      PH_RECOVERY = 2'd2
   } phase_type;

   // Configuration registers.
   logic [SPEED_W-1:0]   limit_ff, limit_in;
   logic [PERCENT_W-1:0] fix_pct_ff, fix_pct_in;
   logic [CHECK_W-1:0]   check_ticks_ff, check_ticks_in;
   logic [TIMER_W-1:0]   fix_ticks_ff, fix_ticks_in;
   logic [TIMER_W-1:0]   recov_ticks_ff, recov_ticks_in;

   // Guard state.
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   phase_type            phase_ff, phase_in;
   logic [CHECK_W-1:0]   check_cnt_ff, check_cnt_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;

   // Per-item working registers.
   logic [SPEED_W-1:0]   sample_ff, sample_in;
   logic [SLOT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 acc_valid_ff, acc_valid_in;
   logic [SPEED_W-1:0]   lo_ff, lo_in;
   logic [SPEED_W-1:0]   hi_ff, hi_in;
   logic                 has_zero_ff, has_zero_in;
   verdict_type          pend_verdict_ff, pend_verdict_in;
   command_type          pend_command_ff, pend_command_in;
   logic [PERCENT_W-1:0] pend_drive_ff, pend_drive_in;

   // Result register.
   verdict_type          rsp_verdict_ff, rsp_verdict_in;
   command_type          rsp_command_ff, rsp_command_in;
   logic [PERCENT_W-1:0] rsp_drive_ff, rsp_drive_in;

   logic [SPEED_W-1:0]   rd_data;
   logic [SLOT_W-1:0]    slot_next;
   logic [CNT_W-1:0]     fill_next;
   logic [CHECK_W-1:0]   check_inc;
   logic [TIMER_W-1:0]   timer_inc;
   logic                 in_monitor;
   logic                 revving;

   // Window storage: written at the write slot, read serially during a check.
   fsog_ram #(
      .WIDTH (SPEED_W),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   // Helper values shared by the update and status logic.
   always_comb begin
      slot_next  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      fill_next  = (fill_ff < CNT_W'(WINDOW)) ? fill_ff + 1'b1 : fill_ff;
      check_inc  = check_cnt_ff + 1'b1;
      timer_inc  = timer_ff + 1'b1;
      in_monitor = (phase_ff != PH_FIXING) && (phase_ff != PH_RECOVERY);
      revving    = (fill_ff != '0) && has_zero_ff && ((hi_ff - lo_ff) > limit_ff);
   end

   assign status.scan_needed = in_monitor && (check_inc == check_ticks_ff);
   assign status.scan_last   = ((CNT_W'(scan_idx_ff) + 1'b1) == fill_ff);

   // Next-state logic for configuration, bookkeeping, scan and result.
   always_comb begin
      limit_in        = limit_ff;
      fix_pct_in      = fix_pct_ff;
      check_ticks_in  = check_ticks_ff;
      fix_ticks_in    = fix_ticks_ff;
      recov_ticks_in  = recov_ticks_ff;
      fill_in         = fill_ff;
      slot_in         = slot_ff;
      phase_in        = phase_ff;
      check_cnt_in    = check_cnt_ff;
      timer_in        = timer_ff;
      sample_in       = sample_ff;
      scan_idx_in     = scan_idx_ff;
      acc_valid_in    = cmd.scan_rd;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      has_zero_in     = has_zero_ff;
      pend_verdict_in = pend_verdict_ff;
      pend_command_in = pend_command_ff;
      pend_drive_in   = pend_drive_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_command_in  = rsp_command_ff;
      rsp_drive_in    = rsp_drive_ff;

      // Register writes; unknown indexes are dropped.
      if (csr_write) begin
         unique case (csr_index)
            CSR_VARIANCE_LIMIT: limit_in       = csr_data;
            CSR_FIX_PERCENT:    fix_pct_in     = csr_data[PERCENT_W-1:0];
            CSR_CHECK_TICKS:    check_ticks_in = csr_data[CHECK_W-1:0];
            CSR_FIX_TICKS:      fix_ticks_in   = csr_data[TIMER_W-1:0];
            CSR_RECOVERY_TICKS: recov_ticks_in = csr_data[TIMER_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         sample_in = req_fan_speed;
      end

      // Store the sample, then advance the phase logic.
      if (cmd.update) begin
         slot_in         = slot_next;
         fill_in         = fill_next;
         pend_verdict_in = VERDICT_NONE;
         pend_command_in = CMD_NONE;
         pend_drive_in   = '0;
         scan_idx_in     = '0;
         lo_in           = '1;
         hi_in           = '0;
         has_zero_in     = 1'b0;
         unique case (phase_ff)
            PH_FIXING: begin
               timer_in = timer_inc;
               if (timer_inc == fix_ticks_ff) begin
                  pend_command_in = CMD_RESUME;
                  phase_in        = PH_RECOVERY;
                  timer_in        = '0;
               end
            end
            PH_RECOVERY: begin
               timer_in = timer_inc;
               if (timer_inc == recov_ticks_ff) begin
                  fill_in      = '0;
                  slot_in      = '0;
                  check_cnt_in = '0;
                  timer_in     = '0;
                  phase_in     = PH_MONITOR;
               end
            end
            default: begin
               phase_in     = PH_MONITOR;
               check_cnt_in = status.scan_needed ? '0 : check_inc;
            end
         endcase
      end

      // Walk the valid window entries.
      if (cmd.scan_rd) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      // Fold in the entry read in the previous cycle.
      if (acc_valid_ff) begin
         if (rd_data == '0) begin
            has_zero_in = 1'b1;
         end
         if (rd_data < lo_ff) begin
            lo_in = rd_data;
         end
         if (rd_data > hi_ff) begin
            hi_in = rd_data;
         end
      end

      // Verdict from the scanned window.
      if (cmd.resolve) begin
         if (revving) begin
            pend_verdict_in = VERDICT_REVVING;
            pend_command_in = CMD_FIX;
            pend_drive_in   = (fix_pct_ff > DRIVE_MAX) ? DRIVE_MAX : fix_pct_ff;
            phase_in        = PH_FIXING;
            timer_in        = '0;
         end else begin
            pend_verdict_in = VERDICT_OK;
         end
      end

      if (cmd.load_rsp) begin
         rsp_verdict_in = pend_verdict_ff;
         rsp_command_in = pend_command_ff;
         rsp_drive_in   = pend_drive_ff;
      end
   end

   // Control state and configuration, set to their reset values by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= VARIANCE_LIMIT_RST;
         fix_pct_ff     <= FIX_PERCENT_RST;
         check_ticks_ff <= CHECK_TICKS_RST;
         fix_ticks_ff   <= FIX_TICKS_RST;
         recov_ticks_ff <= RECOVERY_TICKS_RST;
         fill_ff        <= '0;
         slot_ff        <= '0;
         phase_ff       <= PH_MONITOR;
         check_cnt_ff   <= '0;
         timer_ff       <= '0;
         acc_valid_ff   <= 1'b0;
      end else begin
         limit_ff       <= limit_in;
         fix_pct_ff     <= fix_pct_in;
         check_ticks_ff <= check_ticks_in;
         fix_ticks_ff   <= fix_ticks_in;
         recov_ticks_ff <= recov_ticks_in;
         fill_ff        <= fill_in;
         slot_ff        <= slot_in;
         phase_ff       <= phase_in;
         check_cnt_ff   <= check_cnt_in;
         timer_ff       <= timer_in;
         acc_valid_ff   <= acc_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sample_ff       <= sample_in;
      scan_idx_ff     <= scan_idx_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      has_zero_ff     <= has_zero_in;
      pend_verdict_ff <= pend_verdict_in;
      pend_command_ff <= pend_command_in;
      pend_drive_ff   <= pend_drive_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_command_ff  <= rsp_command_in;
      rsp_drive_ff    <= rsp_drive_in;
   end

   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_command       = rsp_command_ff;
   assign rsp_drive_percent = rsp_drive_ff;

   // The fill count never exceeds the window length.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= CNT_W'(WINDOW))
      else $error("window fill count beyond window length");

   // A check only reads entries that were written.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> (CNT_W'(scan_idx_ff) < fill_ff))
      else $error("window scan past the valid entries");

   // A fix verdict always moves the guard into the fixing phase.
   assert property (@(posedge clock) disable iff (reset)
      cmd.resolve && revving |=> phase_ff == PH_FIXING && timer_ff == '0)
      else $error("revving verdict did not start the fixing phase");

   // A nonzero drive goes out only with the fixed drive command.
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load_rsp) && rsp_drive_ff != '0 |-> rsp_command_ff == CMD_FIX)
      else $error("drive percent without fixed drive command");

endmodule

`default_nettype wire

// File: hw/rtl/fsog_ctrl.sv
`default_nettype none

module fsog_ctrl
   import fsog_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire fsog_status_type status,
   output fsog_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_SCAN,
      S_DRAIN,
      S_EVAL,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Sequencing of one beat: store, optional window scan and verdict, output.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.update = 1'b1;
            state_in   = status.scan_needed ? S_SCAN : S_OUT;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.resolve = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   // State and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // An accepted beat always goes straight to the window write.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_WRITE)
      else $error("accepted beat did not reach the write step");

   // The verdict step only follows a drained scan.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL |-> $past(state_ff) == S_DRAIN)
      else $error("verdict without a completed scan");

   // A held result is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_valid_ff && rsp_stall |-> !cmd.load_rsp)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: hw/rtl/fan_speed_oscillation_guard_unit.sv
`default_nettype none

// Fan speed oscillation guard. Each req beat is one sample tick carrying a fan
// speed; each one yields exactly one rsp beat with a verdict, a command and a
// drive percent. The last WINDOW speeds are kept in a small RAM. A tick that
// needs a window check takes longer than one that does not, set by the serial
// scan of the valid window entries through the single RAM read port. A new
// tick is taken only once the controller is done with the last one. A finished
// result waits in an output register, so the next tick is taken while rsp is
// stalled. Registers are written over the csr port, which is always ready and
// must only be used while no tick is in flight.
module fan_speed_oscillation_guard_unit
   import fsog_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [SPEED_W-1:0]    req_fan_speed,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [CODE_W-1:0]     rsp_verdict,
   output logic      [CODE_W-1:0]     rsp_command,
   output logic      [PERCENT_W-1:0]  rsp_drive_percent,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   fsog_cmd_type    cmd;
   fsog_status_type status;
   logic            csr_write;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   fsog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fsog_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_fan_speed     (req_fan_speed),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_verdict       (rsp_verdict),
      .rsp_command       (rsp_command),
      .rsp_drive_percent (rsp_drive_percent)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import fsog_pkg::*;
;

   localparam int WIN_LEN   = WINDOW_DEF;
   localparam int MAX_WAIT  = 14;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE    = 20;

   typedef enum logic [1:0] {
      GUARD_WATCH   = 2'd0,
      GUARD_FIX     = 2'd1,
      GUARD_RECOVER = 2'd2
   } guard_phase_type;

   typedef struct {
      verdict_type          verdict;
      command_type          command;
      logic [PERCENT_W-1:0] drive;
   } tick_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SPEED_W-1:0]    req_fan_speed = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODE_W-1:0]     rsp_verdict;
   logic [CODE_W-1:0]     rsp_command;
   logic [PERCENT_W-1:0]  rsp_drive_percent;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Speeds waiting to be sent and results the guard still owes us.
   logic [SPEED_W-1:0] pending_speeds[$];
   tick_result_type    owed_results[$];
   int                 errors = 0;

   // Idling controls set per phase by the stimulus.
   logic send_idle = 1'b0;
   logic recv_idle = 1'b0;
   int   hold_request = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   speed_base = 1000;

   // Shadow of the configuration registers.
   logic [SPEED_W-1:0]   cfg_limit = VARIANCE_LIMIT_RST;
   logic [PERCENT_W-1:0] cfg_fix_pct = FIX_PERCENT_RST;
   logic [CHECK_W-1:0]   cfg_check_ticks = CHECK_TICKS_RST;
   logic [TIMER_W-1:0]   cfg_fix_ticks = FIX_TICKS_RST;
   logic [TIMER_W-1:0]   cfg_recovery_ticks = RECOVERY_TICKS_RST;

   // Shadow of the guard's own state.
   logic [SPEED_W-1:0] speed_hist[WIN_LEN];
   int                 hist_fill = 0;
   int                 hist_slot = 0;
   guard_phase_type    guard_phase = GUARD_WATCH;
   logic [CHECK_W-1:0] check_count = '0;
   logic [TIMER_W-1:0] phase_timer = '0;

   fan_speed_oscillation_guard_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_fan_speed     (req_fan_speed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_verdict       (rsp_verdict),
      .rsp_command       (rsp_command),
      .rsp_drive_percent (rsp_drive_percent),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the guard by one sample tick and return what it must report.
   function automatic tick_result_type guard_tick(input logic [SPEED_W-1:0] speed);
      tick_result_type    res;
      logic [SPEED_W-1:0] lo;
      logic [SPEED_W-1:0] hi;
      logic               saw_zero;
      res.verdict = VERDICT_NONE;
      res.command = CMD_NONE;
      res.drive   = '0;

      // The sample enters the window in every phase.
      speed_hist[hist_slot] = speed;
      hist_slot = (hist_slot == WIN_LEN - 1) ? 0 : hist_slot + 1;
      if (hist_fill < WIN_LEN) hist_fill++;

      case (guard_phase)
         GUARD_FIX: begin
            phase_timer = phase_timer + 1'b1;
            if (phase_timer == cfg_fix_ticks) begin
               res.command = CMD_RESUME;
               guard_phase = GUARD_RECOVER;
               phase_timer = '0;
            end
         end
         GUARD_RECOVER: begin
            phase_timer = phase_timer + 1'b1;
            if (phase_timer == cfg_recovery_ticks) begin
               hist_fill   = 0;
               hist_slot   = 0;
               check_count = '0;
               phase_timer = '0;
               guard_phase = GUARD_WATCH;
            end
         end
         default: begin
            guard_phase = GUARD_WATCH;
            check_count = check_count + 1'b1;
            if (check_count == cfg_check_ticks) begin
               check_count = '0;
               lo = '1;
               hi = '0;
               saw_zero = 1'b0;
               for (int i = 0; i < hist_fill; i++) begin
                  if (speed_hist[i] == '0) saw_zero = 1'b1;
                  if (speed_hist[i] < lo) lo = speed_hist[i];
                  if (speed_hist[i] > hi) hi = speed_hist[i];
               end
               if (hist_fill != 0 && saw_zero && (hi - lo) > cfg_limit) begin
                  res.verdict = VERDICT_REVVING;
                  res.command = CMD_FIX;
                  res.drive   = (cfg_fix_pct > DRIVE_MAX) ? DRIVE_MAX : cfg_fix_pct;
                  guard_phase = GUARD_FIX;
                  phase_timer = '0;
               end else begin
                  res.verdict = VERDICT_OK;
               end
            end
         end
      endcase
      return res;
   endfunction

   // Mostly a steady speed with jitter, plus stalls to zero, full scale and noise.
   function automatic logic [SPEED_W-1:0] pick_speed();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel < 2) return '0;
      if (sel == 2) return '1;
      if (sel < 6) return SPEED_W'($urandom);
      return SPEED_W'(speed_base + $urandom_range(0, 200));
   endfunction

   // Sender: one beat per pending speed, with a random wait after each beat when send_idle is set.
   always @(posedge clock) begin : send_proc
      logic offer;
      int   send_wait;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            owed_results.push_back(guard_tick(req_fan_speed));
            offer = 1'b0;
            send_wait = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (!offer) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (pending_speeds.size() != 0) begin
               req_fan_speed <= pending_speeds.pop_front();
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: check each result beat against the oldest owed result.
   always @(posedge clock) begin : recv_proc
      tick_result_type want;
      int              recv_wait;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $display("%0t: result beat with none owed: verdict %0d command %0d drive %0d",
                        $time, rsp_verdict, rsp_command, rsp_drive_percent);
               errors++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_verdict !== want.verdict) begin
                  $display("%0t: verdict expected %0d actual %0d",
                           $time, want.verdict, rsp_verdict);
                  errors++;
               end
               if (rsp_command !== want.command) begin
                  $display("%0t: command expected %0d actual %0d",
                           $time, want.command, rsp_command);
                  errors++;
               end
               if (rsp_drive_percent !== want.drive) begin
                  $display("%0t: drive_percent expected %0d actual %0d",
                           $time, want.drive, rsp_drive_percent);
                  errors++;
               end
            end
            recv_wait = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait != 0) || (hold_left != 0);
      end
   end

   // Returns on a rising edge once nothing is queued, offered or owed. The
   // queues are looked at on the falling edge, after the sender and receiver
   // have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_speeds.size() != 0 || req_valid || owed_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes all five registers back to back; call right after a rising edge.
   task automatic write_regs(input logic [SPEED_W-1:0] limit,
                             input logic [PERCENT_W-1:0] pct,
                             input logic [CHECK_W-1:0] period,
                             input logic [TIMER_W-1:0] fix_len,
                             input logic [TIMER_W-1:0] rec_len);
      logic [CSR_IDX_W-1:0]  idx[5];
      logic [CSR_DATA_W-1:0] val[5];
      idx = '{CSR_VARIANCE_LIMIT, CSR_FIX_PERCENT, CSR_CHECK_TICKS,
              CSR_FIX_TICKS, CSR_RECOVERY_TICKS};
      val = '{limit, CSR_DATA_W'(pct), CSR_DATA_W'(period), fix_len, rec_len};
      for (int i = 0; i < 5; i++) begin
         csr_index <= idx[i];
         csr_data  <= val[i];
         csr_valid <= 1'b1;
         do @(posedge clock);
         while (!csr_ready);
         case (idx[i])
            CSR_VARIANCE_LIMIT: cfg_limit = val[i];
            CSR_FIX_PERCENT:    cfg_fix_pct = val[i][PERCENT_W-1:0];
            CSR_CHECK_TICKS:    cfg_check_ticks = val[i][CHECK_W-1:0];
            CSR_FIX_TICKS:      cfg_fix_ticks = val[i];
            CSR_RECOVERY_TICKS: cfg_recovery_ticks = val[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(input int count);
      @(negedge clock);
      for (int i = 0; i < count; i++) pending_speeds.push_back(pick_speed());
   endtask

   initial begin
      logic [SPEED_W-1:0]   limit_v;
      logic [PERCENT_W-1:0] pct_v;
      logic [CHECK_W-1:0]   period_v;
      logic [TIMER_W-1:0]   fix_v;
      logic [TIMER_W-1:0]   rec_v;
      int                   count_v;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: ten samples with a zero and a full-scale spread trip the
      // guard on the tenth tick with the default drive.
      @(negedge clock);
      pending_speeds = '{16'd1000, 16'd0, 16'hFFFF, 16'd1, 16'd2, 16'h8000,
                         16'h7FFF, 16'd3, 16'd4, 16'd5};
      wait_drained();

      // One-tick phases, drive above 100 saturates, spread just over the limit.
      write_regs(16'hFFFE, 7'd127, 8'd1, 16'd1, 16'd1);
      @(negedge clock);
      pending_speeds = '{16'd7, 16'd9, 16'd0, 16'hFFFF, 16'd3, 16'd4};
      wait_drained();

      // Spread equal to the largest limit is never revving.
      write_regs(16'hFFFF, 7'd127, 8'd1, 16'd1, 16'd1);
      @(negedge clock);
      pending_speeds = '{16'd0, 16'hFFFF, 16'h5555, 16'hAAAA};
      wait_drained();

      // Random phases with fresh settings; timers only change while watching so
      // that a running fix or recovery never has to wrap all the way around.
      for (int p = 0; p < 13; p++) begin
         case ($urandom_range(0, 3))
            0: limit_v = SPEED_W'($urandom_range(0, 100));
            1: limit_v = SPEED_W'($urandom_range(200, 3000));
            2: limit_v = SPEED_W'($urandom);
            default: limit_v = VARIANCE_LIMIT_RST;
         endcase
         pct_v = PERCENT_W'($urandom_range(0, 127));
         period_v = CHECK_W'($urandom_range(1, 12));
         fix_v = cfg_fix_ticks;
         rec_v = cfg_recovery_ticks;
         if (guard_phase == GUARD_WATCH) begin
            if (period_v <= check_count) period_v = check_count + 1'b1;
            fix_v = TIMER_W'($urandom_range(1, 25));
            rec_v = TIMER_W'($urandom_range(1, 25));
         end
         count_v = 100;
         if (p == 11) begin
            period_v = 8'd255;
            count_v = 260;
         end else if (p == 12) begin
            period_v = 8'd0;
            count_v = 260;
         end
         write_regs(limit_v, pct_v, period_v, fix_v, rec_v);
         speed_base = $urandom_range(300, 5000);
         send_idle = (p != 0) && ($urandom_range(0, 2) != 0);
         recv_idle = (p != 0) && ($urandom_range(0, 2) != 0);
         queue_random(count_v);
         // Receiver backs off while the sender keeps offering beats.
         if (p == 3) hold_request <= hold_request + 1;
         wait_drained();
      end

      // Steady speeds without zeros let any fix and recovery run out.
      send_idle = 1'b0;
      recv_idle = 1'b0;
      @(negedge clock);
      repeat (60) pending_speeds.push_back(16'd1000);
      wait_drained();

      // Largest fix timer, zero recovery and zero drive, then zero fix with the largest recovery.
      write_regs(16'd0, 7'd0, 8'd1, 16'hFFFF, 16'd0);
      @(negedge clock);
      pending_speeds = '{16'd0, 16'd5};
      wait_drained();
      queue_random(20);
      wait_drained();
      write_regs(16'hFFFF, 7'd100, 8'd255, 16'd0, 16'hFFFF);
      queue_random(20);
      wait_drained();

      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #800000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/fsog_pkg.sv
hw/rtl/fsog_ram.sv
hw/rtl/fsog_datapath.sv
hw/rtl/fsog_ctrl.sv
hw/rtl/fan_speed_oscillation_guard_unit.sv
tb/sv/tb_top.sv
